/* hw/rtl/mzcpm_pkg.sv */
// Package for the mains zero-cross period monitor: widths, register indexes, types, helpers.
`default_nettype none
package mzcpm_pkg;

  // Period counter width (valid range 8..32)
  localparam int CNT_W = 16;
  localparam int REG_W = 16;
  localparam int IDX_W = 2;

  // Configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_PERIOD_MAX = 2'd0,
    REG_PERIOD_MIN = 2'd1,
    REG_BLANKING   = 2'd2
  } mzcpm_reg_t;

  typedef struct packed {
    logic [REG_W-1:0] period_max;
    logic [REG_W-1:0] period_min;
    logic [REG_W-1:0] blank_len;
  } mzcpm_cfg_t;

  typedef struct packed {
    logic             zero_cross;
    logic [REG_W-1:0] period_ticks;
    logic             freq_error;
    logic             blanking;
  } mzcpm_res_t;

  // Zero-extend a counter value to a common compare width
  function automatic logic [CNT_W+REG_W-1:0] cnt_ext(input logic [CNT_W-1:0] v);
    cnt_ext = {{REG_W{1'b0}}, v};
  endfunction

  // Zero-extend a register value to a common compare width
  function automatic logic [CNT_W+REG_W-1:0] reg_ext(input logic [REG_W-1:0] v);
    reg_ext = {{CNT_W{1'b0}}, v};
  endfunction

  // Saturate a counter value to the 16-bit report width
  function automatic logic [REG_W-1:0] sat_report(input logic [CNT_W-1:0] v);
    logic [CNT_W+REG_W-1:0] w;
    w = cnt_ext(v);
    if (|w[CNT_W+REG_W-1:REG_W]) begin
      sat_report = '1;
    end else begin
      sat_report = w[REG_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/mains_zero_cross_period_monitor_unit.sv */
// Top level of the mains zero-cross period monitor: config registers, input and result stages.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------------------
//  in       | input     | in_valid/in_stall  | edge_seen, power_ok
//  out      | output    | out_valid/out_stall| zero_cross, period_ticks, freq_error, blanking
//  cfg      | input     | cfg_we             | cfg_index, cfg_data
//
// One request per cycle sustained while out_stall is low; each tick request is taken into the
// input register, then passes through the state update into the result register.
// Reset (rst, synchronous) clears both stages, the monitor state and restores register defaults.
// A stall on the output holds the result register; a request waiting in the input register
// then holds too, and in_stall rises only while both stages are full and out_stall is high.
`default_nettype none
module mains_zero_cross_period_monitor_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          edge_seen,
  input  wire logic                          power_ok,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               zero_cross,
  output logic [mzcpm_pkg::REG_W-1:0]        period_ticks,
  output logic                               freq_error,
  output logic                               blanking,
  input  wire logic                          cfg_we,
  input  wire logic [mzcpm_pkg::IDX_W-1:0]   cfg_index,
  input  wire logic [mzcpm_pkg::REG_W-1:0]   cfg_data
);
  import mzcpm_pkg::*;

  mzcpm_cfg_t cfg;
  mzcpm_res_t res;

  logic s1_valid;
  logic s1_edge;
  logic s1_pwr;
  logic advance;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.period_max <= 16'd117;
      cfg.period_min <= 16'd77;
      cfg.blank_len  <= 16'd75;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PERIOD_MAX: cfg.period_max <= cfg_data;
        REG_PERIOD_MIN: cfg.period_min <= cfg_data;
        REG_BLANKING:   cfg.blank_len  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline flow control
  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_edge <= edge_seen;
      s1_pwr  <= power_ok;
    end
  end

  // State update
  mzcpm_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (s1_valid && advance),
    .edge_in (s1_edge),
    .pwr_in  (s1_pwr),
    .cfg     (cfg),
    .res     (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      zero_cross   <= res.zero_cross;
      period_ticks <= res.period_ticks;
      freq_error   <= res.freq_error;
      blanking     <= res.blanking;
    end
  end

`ifndef SYNTHESIS
  // An accepted edge always opens the blanking window
  a_edge_opens_window: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_cross |-> blanking)
    else $error("accepted edge without blanking window");

  // Error flag is sticky across results
  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && freq_error |=> !out_valid || freq_error)
    else $error("frequency error flag cleared");

  // Input stalls only when both stages are full and blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("input stalled without a full pipeline");

  // A blocked output keeps the pending request in the input stage
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && out_stall |=> s1_valid && out_valid)
    else $error("pending request lost under stall");
`endif

endmodule
`default_nettype wire

/* hw/rtl/mzcpm_core.sv */
// Monitor state and per-tick update: period counter, blanking window, sticky error.
`default_nettype none
module mzcpm_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                step,
  input  wire logic                edge_in,
  input  wire logic                pwr_in,
  input  wire mzcpm_pkg::mzcpm_cfg_t cfg,
  output mzcpm_pkg::mzcpm_res_t    res
);
  import mzcpm_pkg::*;

  logic             in_blanking, in_blanking_next;
  logic [CNT_W-1:0] period_counter, period_counter_next;
  logic [REG_W-1:0] blank_countdown, blank_countdown_next;
  logic [CNT_W-1:0] last_period, last_period_next;
  logic             error_flag, error_flag_next;

  logic [CNT_W-1:0] cnt_adv;
  logic [REG_W-1:0] cd_dec;
  logic             accepted;
  logic             out_of_range;

  // Next state for one tick
  always_comb begin
    cnt_adv = (period_counter == '1) ? period_counter : period_counter + 1'b1;
    cd_dec  = (blank_countdown != '0) ? blank_countdown - 1'b1 : blank_countdown;
    out_of_range = (cnt_ext(cnt_adv) >= reg_ext(cfg.period_max)) ||
                   (cnt_ext(cnt_adv) <= reg_ext(cfg.period_min));

    accepted             = 1'b0;
    in_blanking_next     = in_blanking;
    period_counter_next  = cnt_adv;
    blank_countdown_next = blank_countdown;
    last_period_next     = last_period;
    error_flag_next      = error_flag;

    if (!in_blanking) begin
      if (edge_in) begin
        accepted             = 1'b1;
        last_period_next     = cnt_adv;
        period_counter_next  = '0;
        error_flag_next      = error_flag | (pwr_in & out_of_range);
        blank_countdown_next = cfg.blank_len;
        in_blanking_next     = 1'b1;
      end
    end else begin
      // edges in the window are dropped; reopen once the countdown hits zero
      blank_countdown_next = cd_dec;
      if (cd_dec == '0) begin
        in_blanking_next = 1'b0;
      end
    end
  end

  // Result for this tick
  always_comb begin
    res.zero_cross   = accepted;
    res.period_ticks = sat_report(last_period_next);
    res.freq_error   = error_flag_next;
    res.blanking     = in_blanking_next;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_blanking     <= 1'b0;
      period_counter  <= '0;
      blank_countdown <= '0;
      last_period     <= '0;
      error_flag      <= 1'b0;
    end else if (step) begin
      in_blanking     <= in_blanking_next;
      period_counter  <= period_counter_next;
      blank_countdown <= blank_countdown_next;
      last_period     <= last_period_next;
      error_flag      <= error_flag_next;
    end
  end

endmodule
`default_nettype wire

/* verif/tb.sv */
// Testbench for the mains zero-cross period monitor: tick driver, status predictor and checker.
`timescale 1ns / 100ps

module tb;
  import mzcpm_pkg::*;

  localparam int LAT_CYCLES  = 2;
  localparam int STALL_LIMIT = 4000;
  localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;   // unmapped index, writes are dropped

  // One tick request, or a marker that holds the feed until all status is back
  typedef struct {
    logic seen;
    logic pwr;
    logic drain;
  } tick_req_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             edge_seen = 1'b0;
  logic             power_ok = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             zero_cross;
  logic [REG_W-1:0] period_ticks;
  logic             freq_error;
  logic             blanking;
  logic             cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0] cfg_data = '0;

  mains_zero_cross_period_monitor_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .edge_seen    (edge_seen),
    .power_ok     (power_ok),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .zero_cross   (zero_cross),
    .period_ticks (period_ticks),
    .freq_error   (freq_error),
    .blanking     (blanking),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  tick_req_t  tick_feed_q[$];
  mzcpm_res_t status_due_q[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches = 0;
  int results_seen = 0;
  int ticks_sent = 0;
  int edges_taken = 0;
  int quiet_cycles = 0;
  logic mains_power = 1'b1;

  // Shadow copy of the limits and of the monitor state
  logic [REG_W-1:0] max_lim = 16'd117;
  logic [REG_W-1:0] min_lim = 16'd77;
  logic [REG_W-1:0] blank_len = 16'd75;
  logic             win_closed = 1'b0;
  logic [CNT_W-1:0] tick_count = '0;
  logic [REG_W-1:0] blank_left = '0;
  logic [CNT_W-1:0] held_period = '0;
  logic             err_sticky = 1'b0;

  // Advance the shadow monitor by one tick and queue the status it should report
  task automatic step_mains_monitor(input logic seen, input logic pwr);
    mzcpm_res_t res;
    logic [63:0] wide;
    res.zero_cross = 1'b0;
    if (!(&tick_count)) tick_count = tick_count + 1'b1;
    if (!win_closed) begin
      if (seen) begin
        res.zero_cross = 1'b1;
        held_period = tick_count;
        tick_count = '0;
        if (pwr && (held_period >= max_lim || held_period <= min_lim)) err_sticky = 1'b1;
        blank_left = blank_len;
        win_closed = 1'b1;
      end
    end else begin
      // countdown of zero reopens right away: a zero length still blanks one tick
      if (blank_left != '0) blank_left = blank_left - 1'b1;
      if (blank_left == '0) win_closed = 1'b0;
    end
    wide = {{(64-CNT_W){1'b0}}, held_period};
    res.period_ticks = (wide > 64'hFFFF) ? 16'hFFFF : wide[15:0];
    res.freq_error = err_sticky;
    res.blanking = win_closed;
    status_due_q.push_back(res);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < 50)
      $display("MISMATCH result %0d: %s got %0d want %0d", results_seen, what, got, want);
    mismatches++;
  endtask

  // Tick driver: hold the request until taken, then pick the next or idle
  always @(posedge clk) begin : tick_drive
    tick_req_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      edge_seen <= 1'b0;
      power_ok <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        step_mains_monitor(edge_seen, power_ok);
        ticks_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (tick_feed_q.size() != 0 && tick_feed_q[0].drain) begin
          if (status_due_q.size() == 0) void'(tick_feed_q.pop_front());
          in_valid <= 1'b0;
        end else if (tick_feed_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = tick_feed_q.pop_front();
          in_valid <= 1'b1;
          edge_seen <= nxt.seen;
          power_ok <= nxt.pwr;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Status checker and receiver stall
  always @(posedge clk) begin : status_check
    mzcpm_res_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (status_due_q.size() == 0) begin
          report_mismatch("unexpected result, period_ticks", int'(period_ticks), 0);
        end else begin
          want = status_due_q.pop_front();
          if (zero_cross !== want.zero_cross)
            report_mismatch("zero_cross", int'(zero_cross), int'(want.zero_cross));
          if (period_ticks !== want.period_ticks)
            report_mismatch("period_ticks", int'(period_ticks), int'(want.period_ticks));
          if (freq_error !== want.freq_error)
            report_mismatch("freq_error", int'(freq_error), int'(want.freq_error));
          if (blanking !== want.blanking)
            report_mismatch("blanking", int'(blanking), int'(want.blanking));
          if (want.zero_cross) edges_taken++;
        end
        results_seen++;
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog: cycles with no handshake and no register write
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("Timeout: no progress for %0d cycles", STALL_LIMIT);
    $display("mains_zero_cross_period_monitor_unit verification failed");
    $finish;
  end

  task automatic push_tick(input logic seen, input logic pwr, input logic drain);
    tick_req_t r;
    r.seen = seen;
    r.pwr = pwr;
    r.drain = drain;
    tick_feed_q.push_back(r);
  endtask

  // Register write; the block is idle, so the shadow copy changes at once
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_PERIOD_MAX) max_lim = val;
    else if (idx == REG_PERIOD_MIN) min_lim = val;
    else if (idx == REG_BLANKING) blank_len = val;
  endtask

  task automatic set_limits(input logic [REG_W-1:0] mx, input logic [REG_W-1:0] mn,
                            input logic [REG_W-1:0] bl);
    write_reg(REG_PERIOD_MAX, mx);
    write_reg(REG_PERIOD_MIN, mn);
    write_reg(REG_BLANKING, bl);
  endtask

  // Wait until every request is taken and every status is back, then let the pipe settle
  task automatic quiesce();
    do @(negedge clk);
    while (tick_feed_q.size() != 0 || in_valid || status_due_q.size() != 0);
    repeat (LAT_CYCLES + 2) @(negedge clk);
  endtask

  // Mains-like edge train with jittered half periods, contact chatter right after
  // each crossing, power dropouts, and some purely random ticks
  task automatic queue_mains(input int count, input int nominal, input int jitter,
                             input int chatter_pct, input int noise_pct);
    int n;
    int gap;
    int i;
    n = 0;
    while (n < count) begin
      if ($urandom_range(99) < noise_pct) begin
        push_tick(1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0);
        n++;
      end else begin
        gap = nominal - jitter + $urandom_range(2 * jitter);
        push_tick(1'b1, mains_power, 1'b0);
        n++;
        for (i = 1; i < gap && n < count; i++) begin
          push_tick(i < 4 && $urandom_range(99) < chatter_pct, mains_power, 1'b0);
          n++;
        end
      end
      if ($urandom_range(99) < 4) mains_power = !mains_power;
      if ($urandom_range(199) == 0) push_tick(1'b0, 1'b0, 1'b1);
    end
  endtask

  task automatic random_phase(input int count);
    int mx;
    int mn;
    int nom;
    mx = $urandom_range(60, 8);
    if ($urandom_range(4) == 0) mn = $urandom_range(70, mx);
    else mn = $urandom_range(mx, 0);
    set_limits(REG_W'(mx), REG_W'(mn), REG_W'($urandom_range(10, 0)));
    nom = (mx + mn) / 2 + 2;
    queue_mains(count, nom, nom / 3, 30, 10);
    quiesce();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Sender idles lightly, receiver stalls heavily
    send_idle_pct = 16;
    recv_idle_pct = 64;
    set_limits(16'd20, 16'd5, 16'd0);
    @(negedge clk);
    // Directed: power-off acceptance, edge on the reopening tick, in-range period,
    // short period with power off, then short period with power up
    push_tick(1'b1, 1'b0, 1'b0);
    push_tick(1'b1, 1'b1, 1'b0);
    repeat (9) push_tick(1'b0, 1'b1, 1'b0);
    push_tick(1'b1, 1'b1, 1'b0);
    push_tick(1'b1, 1'b0, 1'b0);
    repeat (2) push_tick(1'b0, 1'b0, 1'b0);
    push_tick(1'b1, 1'b0, 1'b0);
    repeat (3) push_tick(1'b0, 1'b1, 1'b0);
    push_tick(1'b1, 1'b1, 1'b0);
    push_tick(1'b0, 1'b1, 1'b0);
    push_tick(1'b1, 1'b0, 1'b0);
    push_tick(1'b0, 1'b0, 1'b1);
    queue_mains(260, 12, 4, 30, 15);
    quiesce();

    // Widest legal band; unmapped index must be ignored
    write_reg(REG_SPARE, 16'hA5A5);
    write_reg(REG_SPARE, 16'h5A5A);
    set_limits(16'hFFFF, 16'h0000, 16'd3);
    queue_mains(240, 9, 5, 40, 20);
    quiesce();

    // Roles swapped; overlapping thresholds and the longest blanking
    send_idle_pct = 64;
    recv_idle_pct = 16;
    set_limits(16'h0000, 16'hFFFF, 16'hFFFF);
    queue_mains(150, 6, 3, 20, 30);
    quiesce();

    set_limits(16'd117, 16'd77, 16'd75);
    queue_mains(250, 97, 20, 30, 5);
    quiesce();
    random_phase(200);

    // No idling from here on
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(200);
    random_phase(200);

    $display("Ran %0d ticks, %0d status words checked, %0d accepted zero crossings",
             ticks_sent, results_seen, edges_taken);
    $display("Limits swept across both extremes and overlapped, blanking 0..65535");
    if (mismatches == 0) begin
      $display("mains_zero_cross_period_monitor_unit verification clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("mains_zero_cross_period_monitor_unit verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/mzcpm_pkg.sv
hw/rtl/mzcpm_core.sv
hw/rtl/mains_zero_cross_period_monitor_unit.sv
verif/tb.sv
